// ----- sv/hrrn_process_scheduler_top_defines.svh -----
// Assertion macros shared by the checker of the scheduler.
`ifndef HRRN_PROCESS_SCHEDULER_TOP_DEFINES_SVH
`define HRRN_PROCESS_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HRRN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HRRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hrrn_pkg.sv -----
// Package of the scheduler: sizes, entry and control types, state codes.
package hrrn_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 32;
    localparam int BURST_BITS  = 16;
    localparam int ORDER_BITS  = 32;
    localparam int IDX_BITS    = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PROD_BITS   = TIME_BITS + BURST_BITS;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ARRIVAL = 1'b1;

    // One waiting entry as it sits in a cell of the ring.
    typedef struct packed {
        logic                  valid;
        logic [ID_BITS-1:0]    id;
        logic [TIME_BITS-1:0]  start;
        logic [BURST_BITS-1:0] left;
        logic [ORDER_BITS-1:0] order;
    } entry_t;

    // Per-cell control: rotate the ring by one, or drop the entry held.
    typedef struct packed {
        logic shift;
        logic kill;
    } cell_ctrl_t;

    // Best candidate found so far by the selection scan.
    typedef struct packed {
        logic                  found;
        logic [IDX_BITS-1:0]   idx;
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] left;
    } best_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- sv/hrrn_cmd_if.sv -----
// Input channel of the scheduler: tick or arrival items.
interface hrrn_cmd_if import hrrn_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [ID_BITS-1:0]    process_id;
    logic [TIME_BITS-1:0]  arrival_stamp;
    logic [BURST_BITS-1:0] burst_length;

    modport source (output valid, mode, process_id, arrival_stamp, burst_length, input ready);
    modport sink   (input valid, mode, process_id, arrival_stamp, burst_length, output ready);

endinterface

// ----- sv/hrrn_status_if.sv -----
// Output channel of the scheduler: running process and drop flag.
interface hrrn_status_if import hrrn_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               running_valid;
    logic [ID_BITS-1:0] running_id;
    logic               arrival_dropped;

    modport source (output valid, running_valid, running_id, arrival_dropped, input ready);
    modport sink   (input valid, running_valid, running_id, arrival_dropped, output ready);

endinterface

// ----- sv/hrrn_process_scheduler_top.sv -----
// Top level of the highest-response-ratio-next scheduler.
// An arrival, or a tick that must pick a new process, rotates the entry ring once
// past one comparator in ST_SCAN and then gives its result from ST_FINISH. A tick
// that keeps the running process goes from ST_IDLE straight to ST_FINISH. A new item
// is taken only in ST_IDLE. The result register lets the next item in
// while a result waits. Reset empties the table and clears time, counters and run state.
module hrrn_process_scheduler_top import hrrn_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    hrrn_cmd_if.sink       cmd,
    hrrn_status_if.source  status
);

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   scan_idx_reg;
    logic                  is_arrival_reg;
    logic                  do_select_reg;
    logic                  slot_found_reg;
    logic [ID_BITS-1:0]    new_id_reg;
    logic [TIME_BITS-1:0]  new_start_reg;
    logic [BURST_BITS-1:0] new_left_reg;

    logic [ORDER_BITS-1:0] arrival_count_reg;
    logic [TIME_BITS-1:0]  now_time_reg;
    logic                  run_active_reg, run_active_next;
    logic [ID_BITS-1:0]    run_id_reg, run_id_next;
    logic [BURST_BITS-1:0] run_left_reg, run_left_next;

    logic                  out_valid_reg;
    logic                  out_running_valid_reg;
    logic [ID_BITS-1:0]    out_running_id_reg;
    logic                  out_dropped_reg;

    logic                  accept;
    logic                  scan_last;
    logic                  insert;
    logic                  finish_fire;
    logic                  tick_select;
    entry_t                head;
    entry_t                tail_in;
    entry_t                cell_q [TABLE_DEPTH];
    cell_ctrl_t            cell_ctrl [TABLE_DEPTH];
    best_t                 best;

    // Ring of cells; the head cell feeds the comparator and the tail.
    assign head = cell_q[0];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t cell_in;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_link
            assign cell_in = cell_q[i+1];
        end

        assign cell_ctrl[i].shift = (state_reg == ST_SCAN);
        assign cell_ctrl[i].kill  = finish_fire && !is_arrival_reg && do_select_reg &&
                                    best.found && (best.idx == IDX_BITS'(i));

        hrrn_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .entry_in  (cell_in),
            .entry_out (cell_q[i])
        );
    end

    // Selection over the entries as they pass the head, in table order.
    hrrn_best_sel u_best_sel (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (accept),
        .step          ((state_reg == ST_SCAN) && !is_arrival_reg && head.valid),
        .head          (head),
        .head_idx      (scan_idx_reg),
        .now_time      (now_time_reg),
        .arrival_count (arrival_count_reg),
        .best          (best)
    );

    // An arrival takes the first free slot it meets during the rotation.
    always_comb
    begin
        insert = (state_reg == ST_SCAN) && is_arrival_reg && !head.valid && !slot_found_reg;
        if (insert)
        begin
            tail_in = '{valid: 1'b1, id: new_id_reg, start: new_start_reg,
                        left: new_left_reg, order: arrival_count_reg};
        end
        else
        begin
            tail_in = head;
        end
    end

    // Sequencer: next state, handshakes and the run state after selection.
    always_comb
    begin
        accept      = cmd.valid && (state_reg == ST_IDLE);
        scan_last   = (scan_idx_reg == IDX_BITS'(TABLE_DEPTH - 1));
        finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || status.ready);
        tick_select = !run_active_reg || (run_left_reg == '0);
        state_next  = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.mode == MODE_ARRIVAL) || tick_select)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        run_active_next = run_active_reg;
        run_id_next     = run_id_reg;
        run_left_next   = run_left_reg;
        if (finish_fire && !is_arrival_reg && do_select_reg)
        begin
            if (best.found)
            begin
                run_active_next = 1'b1;
                run_id_next     = best.id;
                run_left_next   = best.left - 1'b1;
            end
            else
            begin
                run_active_next = 1'b0;
                run_id_next     = '0;
                run_left_next   = '0;
            end
        end
        else if (accept && (cmd.mode == MODE_TICK) && !tick_select)
        begin
            run_left_next = run_left_reg - 1'b1;
        end
    end

    assign cmd.ready = (state_reg == ST_IDLE);

    // Control and scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            scan_idx_reg      <= '0;
            slot_found_reg    <= 1'b0;
            arrival_count_reg <= '0;
            now_time_reg      <= '0;
            run_active_reg    <= 1'b0;
            run_id_reg        <= '0;
            run_left_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_active_reg <= run_active_next;
            run_id_reg     <= run_id_next;
            run_left_reg   <= run_left_next;

            if (accept)
            begin
                scan_idx_reg   <= '0;
                slot_found_reg <= 1'b0;
                if (cmd.mode == MODE_TICK)
                begin
                    now_time_reg <= now_time_reg + 1'b1;
                end
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (insert)
                begin
                    slot_found_reg <= 1'b1;
                end
            end

            if (finish_fire && is_arrival_reg && slot_found_reg)
            begin
                arrival_count_reg <= arrival_count_reg + 1'b1;
            end

            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload captured at the transfer, and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_arrival_reg <= cmd.mode;
            do_select_reg  <= tick_select;
            new_id_reg     <= cmd.process_id;
            new_start_reg  <= cmd.arrival_stamp;
            new_left_reg   <= (cmd.burst_length == '0) ? BURST_BITS'(1) : cmd.burst_length;
        end
        if (finish_fire)
        begin
            out_running_valid_reg <= run_active_next;
            out_running_id_reg    <= run_active_next ? run_id_next : '0;
            out_dropped_reg       <= is_arrival_reg && !slot_found_reg;
        end
    end

    assign status.valid           = out_valid_reg;
    assign status.running_valid   = out_running_valid_reg;
    assign status.running_id      = out_running_id_reg;
    assign status.arrival_dropped = out_dropped_reg;

endmodule

// ----- sv/hrrn_cell.sv -----
// One cell of the entry ring: holds a waiting entry and passes it on when rotating.
module hrrn_cell import hrrn_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     entry_in,
    output entry_t     entry_out
);

    logic                  valid_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [BURST_BITS-1:0] left_reg;
    logic [ORDER_BITS-1:0] order_reg;

    // The valid bit is cleared on reset and when the entry is taken to run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.kill)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= entry_in.valid;
        end
    end

    // The payload simply follows the ring.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            id_reg    <= entry_in.id;
            start_reg <= entry_in.start;
            left_reg  <= entry_in.left;
            order_reg <= entry_in.order;
        end
    end

    assign entry_out = '{valid: valid_reg, id: id_reg, start: start_reg,
                         left: left_reg, order: order_reg};

endmodule

// ----- sv/hrrn_best_sel.sv -----
// Running maximum of the response ratio over the entries passing the ring head.
module hrrn_best_sel import hrrn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  step,
    input  entry_t                head,
    input  logic [IDX_BITS-1:0]   head_idx,
    input  logic [TIME_BITS-1:0]  now_time,
    input  logic [ORDER_BITS-1:0] arrival_count,
    output best_t                 best
);

    logic                  found_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [ID_BITS-1:0]    best_id_reg;
    logic [TIME_BITS-1:0]  best_wait_reg;
    logic [BURST_BITS-1:0] best_left_reg;
    logic [ORDER_BITS-1:0] best_age_reg;

    logic [TIME_BITS-1:0]  head_wait;
    logic [ORDER_BITS-1:0] head_age;
    logic [PROD_BITS-1:0]  lhs;
    logic [PROD_BITS-1:0]  rhs;
    logic                  take;

    // Cross-multiplied ratio compare; on an equal ratio the older arrival wins.
    always_comb
    begin
        head_wait = now_time - head.start;
        head_age  = arrival_count - head.order;
        lhs       = PROD_BITS'(head_wait) * PROD_BITS'(best_left_reg);
        rhs       = PROD_BITS'(best_wait_reg) * PROD_BITS'(head.left);
        take      = step && (!found_reg || (lhs > rhs) ||
                             ((lhs == rhs) && (head_age > best_age_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg  <= head_idx;
            best_id_reg   <= head.id;
            best_wait_reg <= head_wait;
            best_left_reg <= head.left;
            best_age_reg  <= head_age;
        end
    end

    assign best = '{found: found_reg, idx: best_idx_reg, id: best_id_reg,
                    left: best_left_reg};

endmodule

// ----- sv/hrrn_process_scheduler_checker.sv -----
// Port-level assertions of the scheduler and their binding to the top level.
`include "hrrn_process_scheduler_top_defines.svh"

module hrrn_process_scheduler_checker import hrrn_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               status_valid,
    input logic               status_ready,
    input logic               status_running_valid,
    input logic [ID_BITS-1:0] status_running_id,
    input logic               status_arrival_dropped
);

    // A result that waits keeps its value until its transfer.
    `HRRN_ASSERT_NEXT(a_status_hold, status_valid && !status_ready, status_valid && $stable({status_running_valid, status_running_id, status_arrival_dropped}), "status result changed while stalled")

    // The block works on one item at a time.
    `HRRN_ASSERT_NEXT(a_busy_after_transfer, cmd_valid && cmd_ready, !cmd_ready, "input taken while an item is in progress")

    // A new result only appears at the end of an item in progress.
    `HRRN_ASSERT_SAME(a_result_from_item, $rose(status_valid), !$past(cmd_ready), "result appeared without an item in progress")

    // With no running process the reported id is zero.
    `HRRN_ASSERT_SAME(a_idle_id_zero, status_valid && !status_running_valid, status_running_id == '0, "running id set with no running process")

endmodule

bind hrrn_process_scheduler_top hrrn_process_scheduler_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd_valid              (cmd.valid),
    .cmd_ready              (cmd.ready),
    .status_valid           (status.valid),
    .status_ready           (status.ready),
    .status_running_valid   (status.running_valid),
    .status_running_id      (status.running_id),
    .status_arrival_dropped (status.arrival_dropped)
);
